// ===== design/ssgd_pkg.sv =====
`default_nettype none

package ssgd_pkg;

  localparam int COORD_W    = 20;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int ROOT_W     = 28;
  localparam int DIV_STEPS  = 17;
  localparam int DOP_DEN_W  = 52;
  localparam int GAIN_DEN_W = 29;
  localparam int NUM_W      = 50;
  // front end (4) + square root + den/gain setup (1) + divider + back end (4)
  localparam int LAT        = 4 + ROOT_W + 1 + DIV_STEPS + 4;

  localparam logic [23:0] SPEED_RESET = 24'd21065;
  localparam logic [17:0] ONE_Q16     = 18'd65536;
  localparam logic [17:0] HALF_Q16    = 18'd32768;
  localparam logic [17:0] TWO_Q16     = 18'd131072;
  localparam logic [GAIN_DEN_W-1:0] SIX_Q16   = GAIN_DEN_W'(393216);
  // 6*2^32 with the top quotient bits already shifted in
  localparam logic [GAIN_DEN_W-1:0] GAIN_REM0 = GAIN_DEN_W'(196608);
  // ceil(2^23 / 10), exact for values below 2^20
  localparam logic [19:0] RECIP10 = 20'd838861;

  typedef enum logic [2:0] {
    REG_POS     = 3'd0,
    REG_VEL     = 3'd1,
    REG_LEFT    = 3'd2,
    REG_SPEED   = 3'd3,
    REG_COCKPIT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  vol;
    logic [11:0] gs;
    logic [19:0] pitch;
    logic [39:0] range;
    logic        amb;
  } raw_t;

  typedef struct packed {
    logic             inaud;
    logic             ambient;
    logic             dot_pos;
    logic             dot_neg;
    logic [NUM_W-1:0] num;
    logic [19:0]      pitch;
    logic [17:0]      lw;
    logic [17:0]      rw;
    logic [19:0]      vg;
  } chan_t;

  typedef struct packed {
    logic act;
    logic sat_lo;
    logic sat_hi;
  } dflag_t;

endpackage

`default_nettype wire

// ===== design/ssgd_dly.sv =====
`default_nettype none

module ssgd_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/ssgd_sqrt.sv =====
`default_nettype none

module ssgd_sqrt #(
  parameter int ROOT_W = ssgd_pkg::ROOT_W
) (
  input  wire logic                  clk_i,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  output logic      [ROOT_W-1:0]     root_o
);

  localparam int RadW = 2 * ROOT_W;

  logic [RadW-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // one root bit per stage, remainder kept as rad - root^2
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int Bit = ROOT_W - 1 - s;
    logic [RadW-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RadW:0]     trial;
    logic              take;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = ((RadW+1)'(root_in) << (Bit + 1)) | ((RadW+1)'(1) << (2 * Bit));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= take ? (rem_in - trial[RadW-1:0]) : rem_in;
      root_q[s] <= take ? (root_in | (ROOT_W'(1) << Bit)) : root_in;
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/ssgd_div.sv =====
`default_nettype none

module ssgd_div #(
  parameter int DEN_W = ssgd_pkg::GAIN_DEN_W,
  parameter int STEPS = ssgd_pkg::DIV_STEPS
) (
  input  wire logic             clk_i,
  input  wire logic [DEN_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [STEPS-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [STEPS];
  logic [DEN_W-1:0] den_q [STEPS];
  logic [STEPS-1:0] quo_q [STEPS];

  // restoring division, one quotient bit per stage; num_i < den_i expected
  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [STEPS-1:0] quo_in;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign rem_sh = {rem_in, 1'b0};
    assign take   = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? DEN_W'(rem_sh - {1'b0, den_in}) : rem_sh[DEN_W-1:0];
      den_q[s] <= den_in;
      quo_q[s] <= {quo_in[STEPS-2:0], take};
    end
  end

  assign quo_o = quo_q[STEPS-1];

endmodule

`default_nettype wire

// ===== design/spatial_sound_gain_doppler_unit.sv =====
`default_nettype none
// Outputs are valid in the cycle done_o is high. Throughput: one item per
// cycle while busy is low; the 28-stage square root and the two 17-stage
// dividers are fully pipelined, one bit per stage. Reset clears the listener
// registers and all valid bits; busy is high during reset and clears on the
// first edge after release. Results cannot be stalled by the receiver.
module spatial_sound_gain_doppler_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [59:0]        cfg_wdata_i,
  input  wire logic signed [19:0] pos_x_i,
  input  wire logic signed [19:0] pos_y_i,
  input  wire logic signed [19:0] pos_z_i,
  input  wire logic signed [19:0] vel_x_i,
  input  wire logic signed [19:0] vel_y_i,
  input  wire logic signed [19:0] vel_z_i,
  input  wire logic [7:0]         base_volume_i,
  input  wire logic [19:0]        base_pitch_i,
  input  wire logic [39:0]        range_squared_i,
  input  wire logic [11:0]        gain_scale_i,
  input  wire logic               is_ambient_i,
  output logic                    done_o,
  output logic                    audible_o,
  output logic [20:0]             play_rate_o,
  output logic [7:0]              left_level_o,
  output logic [7:0]              right_level_o
);

  localparam int Lat = ssgd_pkg::LAT;
  localparam int RootW = ssgd_pkg::ROOT_W;
  localparam int Steps = ssgd_pkg::DIV_STEPS;
  localparam int DopW = ssgd_pkg::DOP_DEN_W;
  localparam int GainW = ssgd_pkg::GAIN_DEN_W;
  localparam int ChanW = $bits(ssgd_pkg::chan_t);
  localparam int FlagW = $bits(ssgd_pkg::dflag_t);

  // ---------------- control and configuration ----------------
  logic           busy_q;
  logic           accept;
  logic [Lat-1:0] vld_q;
  logic [59:0]    lpos_q, lvel_q, lleft_q;
  logic [23:0]    speed_q;
  logic           cockpit_q;

  assign busy   = busy_q;
  assign accept = start & ~busy_q;
  assign done_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      vld_q     <= '0;
      lpos_q    <= '0;
      lvel_q    <= '0;
      lleft_q   <= '0;
      speed_q   <= ssgd_pkg::SPEED_RESET;
      cockpit_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[Lat-2:0], accept};
      if (cfg_we_i) begin
        unique case (ssgd_pkg::reg_idx_e'(cfg_idx_i))
          ssgd_pkg::REG_POS:     lpos_q    <= cfg_wdata_i;
          ssgd_pkg::REG_VEL:     lvel_q    <= cfg_wdata_i;
          ssgd_pkg::REG_LEFT:    lleft_q   <= cfg_wdata_i;
          ssgd_pkg::REG_SPEED:   speed_q   <= cfg_wdata_i[23:0];
          ssgd_pkg::REG_COCKPIT: cockpit_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- stage 1: differences ----------------
  logic signed [19:0] pos_a [3];
  logic signed [19:0] vel_a [3];
  logic signed [19:0] lp_l [3];
  logic signed [19:0] lv_l [3];
  logic signed [19:0] ll_l [3];
  logic signed [20:0] d_d [3];
  logic signed [20:0] dv_d [3];
  logic signed [20:0] d_q [3];
  logic signed [20:0] dv_q [3];
  ssgd_pkg::raw_t     raw1_q, raw2_q, raw3_q;

  assign pos_a[0] = pos_x_i;
  assign pos_a[1] = pos_y_i;
  assign pos_a[2] = pos_z_i;
  assign vel_a[0] = vel_x_i;
  assign vel_a[1] = vel_y_i;
  assign vel_a[2] = vel_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lp_l[k] = lpos_q[20*k +: 20];
      lv_l[k] = lvel_q[20*k +: 20];
      ll_l[k] = lleft_q[20*k +: 20];
      d_d[k]  = {pos_a[k][19], pos_a[k]} - {lp_l[k][19], lp_l[k]};
      dv_d[k] = {vel_a[k][19], vel_a[k]} - {lv_l[k][19], lv_l[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k]  <= d_d[k];
      dv_q[k] <= dv_d[k];
    end
    raw1_q <= '{vol: base_volume_i, gs: gain_scale_i, pitch: base_pitch_i,
                range: range_squared_i, amb: is_ambient_i};
  end

  // ---------------- stage 2: products ----------------
  logic signed [41:0] sq_d [3];
  logic signed [41:0] dm_d [3];
  logic signed [40:0] pm_d [3];
  logic [40:0]        sq_q [3];
  logic signed [41:0] dm_q [3];
  logic signed [40:0] pm_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = d_q[k] * d_q[k];
      dm_d[k] = d_q[k] * dv_q[k];
      pm_d[k] = d_q[k] * ll_l[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sq_d[k][40:0];
      dm_q[k] <= dm_d[k];
      pm_q[k] <= pm_d[k];
    end
    raw2_q <= raw1_q;
  end

  // ---------------- stage 3: sums ----------------
  logic [41:0]        dsq_q;
  logic signed [42:0] dot_q;
  logic signed [41:0] pan_q;

  always_ff @(posedge clk_i) begin
    dsq_q  <= 42'(sq_q[0]) + 42'(sq_q[1]) + 42'(sq_q[2]);
    dot_q  <= 43'(dm_q[0]) + 43'(dm_q[1]) + 43'(dm_q[2]);
    pan_q  <= 42'(pm_q[0]) + 42'(pm_q[1]) + 42'(pm_q[2]);
    raw3_q <= raw2_q;
  end

  // ---------------- stage 4: range check, pan, magnitudes ----------------
  logic [42:0]        absdot;
  logic [41:0]        abspan;
  logic signed [18:0] panr;
  logic signed [18:0] lw_s, rw_s;
  ssgd_pkg::chan_t    chan4_d, chan4_q;
  logic [39:0]        dsq4_q;

  always_comb begin
    absdot = dot_q[42] ? 43'(-dot_q) : 43'(dot_q);
    abspan = pan_q[41] ? 42'(-pan_q) : 42'(pan_q);
    // fold pan beyond one to its fractional part, keeping the sign
    priority if (pan_q < -42'sd65536) begin
      panr = -$signed({3'b000, abspan[15:0]});
    end else if (pan_q > 42'sd65536) begin
      panr = $signed({3'b000, pan_q[15:0]});
    end else begin
      panr = pan_q[18:0];
    end
    lw_s = $signed({1'b0, ssgd_pkg::ONE_Q16}) + panr;
    rw_s = $signed({1'b0, ssgd_pkg::ONE_Q16}) - panr;
    chan4_d.inaud   = dsq_q > {2'b00, raw3_q.range};
    chan4_d.ambient = raw3_q.amb;
    chan4_d.dot_pos = ~dot_q[42] & (dot_q != '0);
    chan4_d.dot_neg = dot_q[42];
    chan4_d.num     = {absdot[41:0], 8'h00};
    chan4_d.pitch   = raw3_q.pitch;
    chan4_d.lw      = lw_s[17:0];
    chan4_d.rw      = rw_s[17:0];
    chan4_d.vg      = 20'(raw3_q.vol) * 20'(raw3_q.gs);
  end

  always_ff @(posedge clk_i) begin
    chan4_q <= chan4_d;
    dsq4_q  <= dsq_q[39:0];
  end

  // ---------------- square root ----------------
  logic [RootW-1:0] root;
  logic [ChanW-1:0] chan32_raw;
  ssgd_pkg::chan_t  chan32;

  ssgd_sqrt #(.ROOT_W(RootW)) u_sqrt (
    .clk_i (clk_i),
    .rad_i ({dsq4_q, 16'h0000}),
    .root_o(root)
  );

  ssgd_dly #(.W(ChanW), .DEPTH(RootW)) u_dly_sqrt (
    .clk_i(clk_i),
    .d_i  (chan4_q),
    .q_o  (chan32_raw)
  );

  assign chan32 = ssgd_pkg::chan_t'(chan32_raw);

  // ---------------- divider setup ----------------
  logic [DopW-1:0]  den_q;
  logic [GainW-1:0] gden_q;
  logic             act_q;
  ssgd_pkg::chan_t  chan33_q;
  ssgd_pkg::dflag_t flag33;

  always_ff @(posedge clk_i) begin
    den_q    <= DopW'(root) * DopW'(speed_q);
    gden_q   <= GainW'(root) + ssgd_pkg::SIX_Q16;
    act_q    <= chan32.ambient & (root != '0) & (chan32.dot_pos | chan32.dot_neg);
    chan33_q <= chan32;
  end

  always_comb begin
    flag33.act    = act_q;
    flag33.sat_lo = chan33_q.dot_pos & ({1'b0, chan33_q.num, 1'b0} >= den_q);
    flag33.sat_hi = chan33_q.dot_neg & ({2'b00, chan33_q.num} >= den_q);
  end

  logic [Steps-1:0]       dop_quo, gain_quo;
  logic [ChanW+FlagW-1:0] side50;
  ssgd_pkg::chan_t        chan50;
  ssgd_pkg::dflag_t       flag50;

  ssgd_div #(.DEN_W(DopW), .STEPS(Steps)) u_div_dop (
    .clk_i(clk_i),
    .num_i({2'b00, chan33_q.num}),
    .den_i(den_q),
    .quo_o(dop_quo)
  );

  ssgd_div #(.DEN_W(GainW), .STEPS(Steps)) u_div_gain (
    .clk_i(clk_i),
    .num_i(ssgd_pkg::GAIN_REM0),
    .den_i(gden_q),
    .quo_o(gain_quo)
  );

  ssgd_dly #(.W(ChanW + FlagW), .DEPTH(Steps)) u_dly_div (
    .clk_i(clk_i),
    .d_i  ({chan33_q, flag33}),
    .q_o  (side50)
  );

  assign chan50 = ssgd_pkg::chan_t'(side50[ChanW+FlagW-1:FlagW]);
  assign flag50 = ssgd_pkg::dflag_t'(side50[FlagW-1:0]);

  // ---------------- stage E: Doppler factor, gain * 13 ----------------
  logic [17:0]      factor_d, factor_q;
  logic [19:0]      g13_q;
  logic [16:0]      gq_e_q, gq_f_q;
  ssgd_pkg::chan_t  chan51_q, chan52_q, chan53_q;

  always_comb begin
    priority if (!flag50.act) begin
      factor_d = ssgd_pkg::ONE_Q16;
    end else if (flag50.sat_lo) begin
      factor_d = ssgd_pkg::HALF_Q16;
    end else if (flag50.sat_hi) begin
      factor_d = ssgd_pkg::TWO_Q16;
    end else if (chan50.dot_pos) begin
      factor_d = ssgd_pkg::ONE_Q16 - 18'(dop_quo[Steps-1:1]);
    end else begin
      factor_d = ssgd_pkg::ONE_Q16 + 18'(dop_quo[Steps-1:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    g13_q    <= 20'(gain_quo) * 20'd13;
    gq_e_q   <= gain_quo;
    chan51_q <= chan50;
  end

  // ---------------- stage F: play rate, divide by ten ----------------
  logic [37:0] rate_prod;
  logic [39:0] g10_prod;
  logic [20:0] rate_f_q, rate_g_q;
  logic [16:0] g10_q;

  assign rate_prod = 38'(chan51_q.pitch) * 38'(factor_q);
  assign g10_prod  = 40'(g13_q) * 40'(ssgd_pkg::RECIP10);

  always_ff @(posedge clk_i) begin
    rate_f_q <= rate_prod[36:16];
    g10_q    <= g10_prod[39:23];
    gq_f_q   <= gq_e_q;
    chan52_q <= chan51_q;
  end

  // ---------------- stage G: gain times volume and scale ----------------
  logic [16:0] gain_sel;
  logic [36:0] pg_q;

  assign gain_sel = cockpit_q ? gq_f_q : g10_q;

  always_ff @(posedge clk_i) begin
    pg_q     <= 37'(gain_sel) * 37'(chan52_q.vg);
    rate_g_q <= rate_f_q;
    chan53_q <= chan52_q;
  end

  // ---------------- stage H: pan weights, saturate, output ----------------
  logic [54:0] lprod, rprod;
  logic [7:0]  lsat, rsat;

  assign lprod = 55'(chan53_q.lw) * 55'(pg_q);
  assign rprod = 55'(chan53_q.rw) * 55'(pg_q);
  assign lsat  = (lprod[54:49] != '0) ? 8'hFF : lprod[48:41];
  assign rsat  = (rprod[54:49] != '0) ? 8'hFF : rprod[48:41];

  always_ff @(posedge clk_i) begin
    audible_o     <= ~chan53_q.inaud;
    play_rate_o   <= chan53_q.inaud ? '0 : rate_g_q;
    left_level_o  <= chan53_q.inaud ? '0 : lsat;
    right_level_o <= chan53_q.inaud ? '0 : rsat;
  end

endmodule

`default_nettype wire

// ===== design/ssgd_chk.sv =====
`default_nettype none

module ssgd_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               cfg_we_i,
  input wire logic [2:0]         cfg_idx_i,
  input wire logic [59:0]        cfg_wdata_i,
  input wire logic signed [19:0] pos_x_i,
  input wire logic signed [19:0] pos_y_i,
  input wire logic signed [19:0] pos_z_i,
  input wire logic signed [19:0] vel_x_i,
  input wire logic signed [19:0] vel_y_i,
  input wire logic signed [19:0] vel_z_i,
  input wire logic [7:0]         base_volume_i,
  input wire logic [19:0]        base_pitch_i,
  input wire logic [39:0]        range_squared_i,
  input wire logic [11:0]        gain_scale_i,
  input wire logic               is_ambient_i,
  input wire logic               done_o,
  input wire logic               audible_o,
  input wire logic [20:0]        play_rate_o,
  input wire logic [7:0]         left_level_o,
  input wire logic [7:0]         right_level_o
);

  // an out-of-range item carries no rate or level
  a_inaudible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !audible_o) |-> (play_rate_o == '0 && left_level_o == '0 &&
                                right_level_o == '0))
    else $error("inaudible item with nonzero fields");

  // pipeline is flushed by reset: no strobe right after release
  a_no_done_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

  // no item may be taken on the first edge after reset
  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> busy)
    else $error("item accepted on first edge after reset");

endmodule

bind spatial_sound_gain_doppler_unit ssgd_chk u_ssgd_chk (.*);

`default_nettype wire

// ===== tb/spatial_sound_gain_doppler_unit_test.sv =====
`timescale 1ns / 1ps

module spatial_sound_gain_doppler_unit_test;
  import ssgd_pkg::*;

  typedef struct packed {
    logic signed [19:0] px, py, pz, vx, vy, vz;
    logic [7:0]         vol;
    logic [19:0]        pitch;
    logic [39:0]        range;
    logic [11:0]        gs;
    logic               amb;
  } chan_item_t;

  typedef struct packed {
    logic        aud;
    logic [20:0] rate;
    logic [7:0]  lvl;
    logic [7:0]  rvl;
  } mix_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i, rst_ni;
  logic start, busy, done_o, audible_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [59:0] cfg_wdata_i;
  logic signed [19:0] pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i;
  logic [7:0] base_volume_i, left_level_o, right_level_o;
  logic [19:0] base_pitch_i;
  logic [39:0] range_squared_i;
  logic [11:0] gain_scale_i;
  logic is_ambient_i;
  logic [20:0] play_rate_o;

  spatial_sound_gain_doppler_unit u_dut (.*);

  // listener copy used by the predictor
  logic [59:0] lis_pos, lis_vel, lis_left;
  logic [23:0] snd_speed;
  logic        cockpit;

  chan_item_t pending_q[$];
  mix_t       mix_q[$];
  int         errors = 0;
  int         cycles = 0;
  int         burst_left = 0, gap_left = 0;
  bit         hold_off = 0;

  function automatic longint lane_of(logic [59:0] p, int k);
    logic signed [19:0] v;
    v = p[20*k +: 20];
    return longint'(v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic mix_t mix_levels(chan_item_t c);
    longint d[3], dv[3];
    longint dot, pan;
    longint unsigned dsq, span, factor, gain, lw, rw, lvl, rvl, den, num, rem, t;
    mix_t m;
    logic signed [19:0] p[3], v[3];
    p = '{c.px, c.py, c.pz};
    v = '{c.vx, c.vy, c.vz};
    dsq = 0; dot = 0; pan = 0;
    m = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'(p[k]) - lane_of(lis_pos, k);
      dv[k] = longint'(v[k]) - lane_of(lis_vel, k);
      dsq += longint'(d[k] * d[k]);
      dot += d[k] * dv[k];
      pan += d[k] * lane_of(lis_left, k);
    end
    if (dsq > {24'd0, c.range}) return m;
    span = (dsq == 0) ? 0 : isqrt(dsq << 16);
    factor = 65536;
    if (c.amb && span != 0 && dot != 0) begin
      den = span * snd_speed;
      num = (dot < 0 ? -dot : dot) << 8;
      if (dot > 0 && num * 2 >= den) factor = 32768;
      else if (dot < 0 && num >= den) factor = 131072;
      else begin
        rem = num; t = 0;
        for (int k = 0; k < 16; k++) begin
          rem <<= 1; t <<= 1;
          if (rem >= den) begin
            rem -= den;
            t |= 1;
          end
        end
        factor = dot > 0 ? 65536 - t : 65536 + t;
      end
    end
    gain = (64'd6 << 32) / (span + (64'd6 << 16));
    if (!cockpit) gain = gain * 13 / 10;
    if (pan < -65536) pan = -((-pan) & 64'hFFFF);
    else if (pan > 65536) pan = pan & 64'hFFFF;
    lw = 65536 + pan;
    rw = 65536 - pan;
    lvl = (lw * c.vol * gain * c.gs) >> 41;
    rvl = (rw * c.vol * gain * c.gs) >> 41;
    m.aud = 1'b1;
    m.rate = 21'((c.pitch * factor) >> 16);
    m.lvl = lvl > 255 ? 8'd255 : 8'(lvl);
    m.rvl = rvl > 255 ? 8'd255 : 8'(rvl);
    return m;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver: bursts with gaps, holds start for back-to-back items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        mix_q.push_back(mix_levels(pending_q.pop_front()));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_off &&
                     !(start && !busy && pending_q.size() == 0)) begin
          start <= 1'b1;
          {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, base_volume_i,
           base_pitch_i, range_squared_i, gain_scale_i, is_ambient_i} <= pending_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mix_t want;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (mix_q.size() == 0) begin
        $display("%0t unexpected result aud=%0d rate=%0d l=%0d r=%0d", $realtime,
                 audible_o, play_rate_o, left_level_o, right_level_o);
        errors = errors + 1;
      end else begin
        want = mix_q.pop_front();
        if (want.aud !== audible_o) begin
          $display("%0t audible exp %0d got %0d", $realtime, want.aud, audible_o);
          errors = errors + 1;
        end
        if (want.rate !== play_rate_o) begin
          $display("%0t play_rate exp %0d got %0d", $realtime, want.rate, play_rate_o);
          errors = errors + 1;
        end
        if (want.lvl !== left_level_o) begin
          $display("%0t left_level exp %0d got %0d", $realtime, want.lvl, left_level_o);
          errors = errors + 1;
        end
        if (want.rvl !== right_level_o) begin
          $display("%0t right_level exp %0d got %0d", $realtime, want.rvl, right_level_o);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("spatial_sound_gain_doppler_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [19:0] rnd_coord(int spread);
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return 20'($urandom);
      default: return 20'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic chan_item_t rnd_item();
    chan_item_t c;
    c.px = rnd_coord(3000); c.py = rnd_coord(3000); c.pz = rnd_coord(3000);
    c.vx = rnd_coord(2000); c.vy = rnd_coord(2000); c.vz = rnd_coord(2000);
    c.vol = 8'($urandom);
    c.pitch = 20'($urandom);
    case ($urandom_range(0, 3))
      0: c.range = 40'({$urandom, $urandom});
      1: c.range = 40'hFF_FFFF_FFFF;
      default: c.range = 40'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 8);
    endcase
    c.gs = 12'($urandom);
    c.amb = $urandom_range(0, 3) != 0;
    return c;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [59:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_POS:     lis_pos = val;
      REG_VEL:     lis_vel = val;
      REG_LEFT:    lis_left = val;
      REG_SPEED:   snd_speed = val[23:0];
      REG_COCKPIT: cockpit = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || mix_q.size() > 0 || start) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  function automatic logic [59:0] rnd_vec(int spread);
    return {rnd_coord(spread), rnd_coord(spread), rnd_coord(spread)};
  endfunction

  initial begin
    chan_item_t c;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, base_volume_i,
     base_pitch_i, range_squared_i, gain_scale_i, is_ambient_i} = '0;
    lis_pos = '0; lis_vel = '0; lis_left = '0;
    snd_speed = SPEED_RESET; cockpit = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: zero distance, extremes, approach/recede, out of range
    c = '0; c.vol = 8'd255; c.pitch = 20'hFFFFF; c.range = '1; c.gs = 12'hFFF; c.amb = 1;
    pending_q.push_back(c);
    c.vx = 20'sd100; pending_q.push_back(c);
    c.px = 20'sd256; c.vx = 20'sd0; pending_q.push_back(c);
    c.vx = 20'sd5000; pending_q.push_back(c);
    c.vx = -20'sd5000; pending_q.push_back(c);
    c.vx = 20'sh7FFFF; pending_q.push_back(c);
    c.vx = 20'sh80000; pending_q.push_back(c);
    c.px = 20'sh80000; c.py = 20'sh80000; c.pz = 20'sh80000; pending_q.push_back(c);
    c.px = 20'sh7FFFF; c.py = 20'sh7FFFF; c.pz = 20'sh7FFFF; pending_q.push_back(c);
    c.range = '0; pending_q.push_back(c);
    c.px = 20'sd1; c.py = 0; c.pz = 0; c.range = 40'd1; pending_q.push_back(c);
    c.range = '1; c.amb = 0; c.vol = 0; pending_q.push_back(c);
    c.vol = 8'd128; c.gs = 12'd256; c.pitch = 20'd44100; pending_q.push_back(c);
    drain();

    // pan terms beyond +-1 and zero speed saturation
    write_reg(REG_LEFT, {20'sd0, 20'sd0, 20'sd512});
    write_reg(REG_SPEED, 60'd0);
    write_reg(REG_COCKPIT, 60'd1);
    c = '0; c.vol = 8'd200; c.pitch = 20'd48000; c.range = '1; c.gs = 12'd256; c.amb = 1;
    c.px = 20'sd300; c.vx = 20'sd10; pending_q.push_back(c);
    c.px = -20'sd300; pending_q.push_back(c);
    c.vx = -20'sd10; pending_q.push_back(c);
    c.px = 20'sd100; pending_q.push_back(c);
    drain();
    write_reg(REG_COCKPIT, 60'd0);
    write_reg(reg_idx_e'(3'd7), 60'hFFF); // unmapped index: ignored

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_reg(REG_SPEED, 60'd16777215);
        1: write_reg(REG_SPEED, 60'd1);
        default: write_reg(REG_SPEED, 60'($urandom_range(1, 24'hFFFFFF)));
      endcase
      write_reg(REG_POS, ph == 1 ? 60'hFFF_FFFF_FFFF_FFFF : rnd_vec(2000));
      write_reg(REG_VEL, ph == 2 ? 60'h800008000080000 : rnd_vec(2000));
      write_reg(REG_LEFT, ph == 3 ? 60'h7FFFF7FFFF7FFFF : rnd_vec(400));
      write_reg(REG_COCKPIT, 60'(ph & 1));
      for (int i = 0; i < 100; i++) pending_q.push_back(rnd_item());
      if (ph == 4) begin
        // pause until everything in flight has come back
        while (pending_q.size() > 50) @(posedge clk_i);
        hold_off = 1;
        while (mix_q.size() > 0) @(posedge clk_i);
        hold_off = 0;
      end
      drain();
    end
    repeat (LAT + 10) @(posedge clk_i);
    if (errors == 0)
      $display("spatial_sound_gain_doppler_unit: match");
    else
      $display("spatial_sound_gain_doppler_unit: mismatch");
    $finish;
  end

endmodule

// ===== spatial_sound_gain_doppler_unit.f =====
design/ssgd_pkg.sv
design/ssgd_dly.sv
design/ssgd_sqrt.sv
design/ssgd_div.sv
design/spatial_sound_gain_doppler_unit.sv
design/ssgd_chk.sv
tb/spatial_sound_gain_doppler_unit_test.sv
